// File: rtl/pss_pkg.sv
// Package with the types, sizes and codes of the positional sequence store.
`default_nettype none

package pss_pkg;

  localparam int CAPACITY = 64;

  // Field widths of the command and result.
  localparam int KIND_W   = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Storage sizes that follow from the capacity.
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2
  } pss_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } pss_status_e;

  typedef struct packed {
    pss_kind_e                 kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } pss_cmd_t;

  typedef struct packed {
    pss_status_e               status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;
  } pss_rsp_t;

endpackage

`default_nettype wire

// File: rtl/positional_sequence_store.sv
// Top level of the positional sequence store: command sequencer around the entry RAM.
//
//   channel   ports                    handshake
//   command   start, busy, cmd_i       taken at a clock edge with start high and busy low
//   result    done_o, rsp_o            valid for the single cycle done_o is high
//
// A request that is answered without moving entries (bad position, full store, insert at
// the tail, remove of the last entry, unused kind) never raises busy; a good read waits
// in S_READ for the registered RAM data. With n entries held, an insert at p < n runs
// S_INS and then S_INS_LAST, a remove at p < n - 1 runs S_REM, and the RAM moves one entry
// per cycle, read on one cycle and written back one address over on the next.
// Busy is high in every cycle of a request but the first, and the result strobe comes in
// the cycle after the last cycle of the request. Reset clears the count and the sequencer;
// the entry RAM is not cleared, since only written entries are ever read. The receiver
// cannot stall, so results never wait.
`default_nettype none

module positional_sequence_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire pss_pkg::pss_cmd_t cmd_i,
  output logic                   done_o,
  output pss_pkg::pss_rsp_t      rsp_o
);

  import pss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_REM,
    S_READ
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ADDR_W-1:0]    src_q, src_d;
  logic [ADDR_W-1:0]    pos_q, pos_d;
  logic [DATA_W-1:0]    val_q, val_d;
  logic                 done_q, done_d;
  pss_rsp_t             rsp_q, rsp_d;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [ADDR_W-1:0]    last_addr;
  logic [ADDR_W-1:0]    cmd_addr;

  pss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pos_ext   = CMP_W'(cmd_i.position);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign last_addr = ADDR_W'(cnt_q - CNT_W'(1));
  assign cmd_addr  = ADDR_W'(cmd_i.position);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    src_d     = src_q;
    pos_d     = pos_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = src_q;
    ram_wdata = ram_rdata;
    ram_raddr = src_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          pos_d             = cmd_addr;
          val_d             = cmd_i.value;
          rsp_d.status      = ST_BADPOS;
          rsp_d.read_value  = '0;
          unique case (cmd_i.kind)
            KIND_INSERT: begin
              if (pos_ext > cnt_ext) begin
                done_d = 1'b1;
              end else if (cnt_q == CNT_W'(CAPACITY)) begin
                rsp_d.status = ST_FULL;
                done_d       = 1'b1;
              end else if (pos_ext == cnt_ext) begin
                // Appending at the tail needs no entry to move.
                ram_we       = 1'b1;
                ram_waddr    = cmd_addr;
                ram_wdata    = cmd_i.value;
                cnt_d        = cnt_q + CNT_W'(1);
                rsp_d.status = ST_OK;
                done_d       = 1'b1;
              end else begin
                ram_raddr = last_addr;
                src_d     = last_addr;
                state_d   = S_INS;
              end
            end
            KIND_REMOVE: begin
              if (pos_ext < cnt_ext) begin
                if (cmd_addr == last_addr) begin
                  cnt_d        = cnt_q - CNT_W'(1);
                  rsp_d.status = ST_OK;
                  done_d       = 1'b1;
                end else begin
                  ram_raddr = cmd_addr + ADDR_W'(1);
                  src_d     = cmd_addr + ADDR_W'(1);
                  state_d   = S_REM;
                end
              end else begin
                done_d = 1'b1;
              end
            end
            KIND_READ: begin
              if (pos_ext < cnt_ext) begin
                ram_raddr = cmd_addr;
                state_d   = S_READ;
              end else begin
                rsp_d.read_value = '1;
                done_d           = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        // The entry read last cycle moves one place toward the tail.
        ram_we    = 1'b1;
        ram_waddr = src_q + ADDR_W'(1);
        if (src_q == pos_q) begin
          state_d = S_INS_LAST;
        end else begin
          ram_raddr = src_q - ADDR_W'(1);
          src_d     = src_q - ADDR_W'(1);
        end
      end
      S_INS_LAST: begin
        ram_we       = 1'b1;
        ram_waddr    = pos_q;
        ram_wdata    = val_q;
        cnt_d        = cnt_q + CNT_W'(1);
        rsp_d.status = ST_OK;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      S_REM: begin
        // The entry read last cycle moves one place toward the head.
        ram_we    = 1'b1;
        ram_waddr = src_q - ADDR_W'(1);
        if (src_q == last_addr) begin
          cnt_d        = cnt_q - CNT_W'(1);
          rsp_d.status = ST_OK;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ram_raddr = src_q + ADDR_W'(1);
          src_d     = src_q + ADDR_W'(1);
        end
      end
      S_READ: begin
        rsp_d.status     = ST_OK;
        rsp_d.read_value = $signed(ram_rdata);
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      rsp_d.count = COUNT_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      src_q   <= '0;
      pos_q   <= '0;
      val_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      src_q   <= src_d;
      pos_q   <= pos_d;
      val_q   <= val_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/pss_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
